// ===== rtl/ial_pkg.sv =====
// Shared types and constants for the indexed array list core.
// Used by the controller, the datapath, the top level and the checker.
package ial_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int POS_W    = 10;
  localparam int CNT_W    = 11;
  localparam int WORD_W   = 32;

  typedef enum logic [2:0] {
    MODE_APPEND      = 3'd0,
    MODE_INSERT      = 3'd1,
    MODE_REMOVE_AT   = 3'd2,
    MODE_REMOVE_LAST = 3'd3,
    MODE_SET         = 3'd4,
    MODE_GET         = 3'd5,
    MODE_CLEAR       = 3'd6
  } ial_mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } ial_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DRAIN,
    S_FILL,
    S_READ,
    S_DONE
  } ial_state_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;
  } ial_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] word_out;
    logic [CNT_W-1:0]         count;
  } ial_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic latch_res;
    logic wr_word;
    logic upd_count;
    logic shift_init;
    logic shift_step;
    logic rd_pos;
    logic cap_read;
    logic out_load;
  } ial_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic       chk_ok;
    logic       at_tail;
    logic       shift_last;
  } ial_sts_t;

endpackage

// ===== rtl/ial_ctrl.sv =====
// Request sequencer for the indexed array list core.
// Depends on ial_pkg; drives ial_dpath through ial_cmd_t.
module ial_ctrl
  import ial_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ial_sts_t sts,
  output ial_cmd_t cmd
);

  ial_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (sts.chk_ok) begin
          priority if (sts.mode == MODE_INSERT && !sts.at_tail) begin
            state_nxt = S_SHIFT;
          end else if (sts.mode == MODE_REMOVE_AT && !sts.at_tail) begin
            state_nxt = S_SHIFT;
          end else if (sts.mode == MODE_GET) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (sts.shift_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = (sts.mode == MODE_INSERT) ? S_FILL : S_DONE;
      end
      S_FILL:  state_nxt = S_DONE;
      S_READ:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_req = in_valid;
      end
      S_EXEC: begin
        cmd.latch_res = 1'b1;
        if (sts.chk_ok) begin
          unique case (sts.mode)
            MODE_APPEND: begin
              cmd.wr_word   = 1'b1;
              cmd.upd_count = 1'b1;
            end
            MODE_INSERT: begin
              cmd.wr_word    = sts.at_tail;
              cmd.upd_count  = sts.at_tail;
              cmd.shift_init = !sts.at_tail;
            end
            MODE_REMOVE_AT: begin
              cmd.upd_count  = sts.at_tail;
              cmd.shift_init = !sts.at_tail;
            end
            MODE_REMOVE_LAST, MODE_CLEAR: begin
              cmd.upd_count = 1'b1;
            end
            MODE_SET: begin
              cmd.wr_word = 1'b1;
            end
            MODE_GET: begin
              cmd.rd_pos = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
      end
      S_DRAIN: begin
        // remove finishes here; insert still owes the new word
        cmd.upd_count = (sts.mode == MODE_REMOVE_AT);
      end
      S_FILL: begin
        cmd.wr_word   = 1'b1;
        cmd.upd_count = 1'b1;
      end
      S_READ: begin
        cmd.cap_read = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/ial_dpath.sv =====
// Element store, count, shift pointer and result registers of the list core.
// Depends on ial_pkg; commanded by ial_ctrl.
module ial_dpath
  import ial_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ial_in_t  in_req,
  input  ial_cmd_t cmd,
  output ial_sts_t sts,
  output ial_out_t out_rsp
);

  logic [WORD_W-1:0] mem [CAPACITY];

  ial_in_t           req_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [WORD_W-1:0] rd_data_r;
  logic [1:0]        res_status_r;
  logic [WORD_W-1:0] res_word_r;
  ial_out_t          out_r;

  logic [CNT_W-1:0]  pos_ext;
  logic [ADDR_W-1:0] pos_addr;
  logic [ADDR_W-1:0] last_addr;
  logic              full;
  ial_status_t       chk_status;
  logic              shift_up;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  assign pos_ext   = CNT_W'(req_r.position);
  assign pos_addr  = ADDR_W'(req_r.position);
  assign last_addr = ADDR_W'(count_r - CNT_W'(1));
  assign full      = (count_r >= CNT_W'(CAPACITY));
  assign shift_up  = (req_r.mode == MODE_INSERT);

  always_comb begin
    chk_status = ST_OK;
    unique case (req_r.mode)
      MODE_APPEND: begin
        if (full) chk_status = ST_FULL;
      end
      MODE_INSERT: begin
        priority if (pos_ext > count_r) chk_status = ST_RANGE;
        else if (full)                  chk_status = ST_FULL;
        else                            chk_status = ST_OK;
      end
      MODE_REMOVE_AT, MODE_SET, MODE_GET: begin
        if (pos_ext >= count_r) chk_status = ST_RANGE;
      end
      MODE_REMOVE_LAST: begin
        if (count_r == '0) chk_status = ST_EMPTY;
      end
      default: ;
    endcase
  end

  assign sts.mode       = req_r.mode;
  assign sts.chk_ok     = (chk_status == ST_OK);
  assign sts.at_tail    = shift_up ? (pos_ext == count_r)
                                   : (pos_ext + CNT_W'(1) == count_r);
  assign sts.shift_last = shift_up ? (src_r == pos_addr) : (src_r == last_addr);

  always_comb begin
    count_nxt = count_r;
    unique case (req_r.mode)
      MODE_APPEND, MODE_INSERT:         count_nxt = count_r + CNT_W'(1);
      MODE_REMOVE_AT, MODE_REMOVE_LAST: count_nxt = count_r - CNT_W'(1);
      MODE_CLEAR:                       count_nxt = '0;
      default: ;
    endcase
  end

  always_comb begin
    src_nxt = src_r;
    if (cmd.shift_init) begin
      src_nxt = shift_up ? last_addr : pos_addr + ADDR_W'(1);
    end else if (cmd.shift_step) begin
      src_nxt = shift_up ? src_r - ADDR_W'(1) : src_r + ADDR_W'(1);
    end
  end

  // a pending move always owns the write port; the controller keeps word writes clear of it
  assign mem_we    = wr_pend_r || cmd.wr_word;
  assign mem_waddr = wr_pend_r ? wr_addr_r
                   : ((req_r.mode == MODE_APPEND) ? ADDR_W'(count_r) : pos_addr);
  assign mem_wdata = wr_pend_r ? rd_data_r : req_r.word_in;
  assign mem_re    = cmd.shift_step || cmd.rd_pos;
  assign mem_raddr = cmd.shift_step ? src_r : pos_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      if (cmd.upd_count) count_r <= count_nxt;
      wr_pend_r <= cmd.shift_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_req;
    src_r <= src_nxt;
    if (cmd.shift_step) begin
      wr_addr_r <= shift_up ? src_r + ADDR_W'(1) : src_r - ADDR_W'(1);
    end
    if (cmd.latch_res) begin
      res_status_r <= chk_status;
      res_word_r   <= (req_r.mode == MODE_GET && chk_status != ST_OK) ? '1 : '0;
    end else if (cmd.cap_read) begin
      res_word_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_r.status   <= res_status_r;
      out_r.word_out <= res_word_r;
      out_r.count    <= count_r;
    end
  end

  assign out_rsp = out_r;

endmodule

// ===== rtl/indexed_array_list_core.sv =====
// Top level of the indexed array list core: sequencer plus datapath.
// Depends on ial_pkg, ial_ctrl and ial_dpath.
//
//   channel   direction  handshake            payload
//   in_       request    in_valid / in_stall  ial_in_t  (mode, position, word_in)
//   out_      response   out_valid/out_stall  ial_out_t (status, word_out, count)
//
// One request at a time. Append, set, remove last, clear, insert or remove at the
// tail and every rejected request go from execute straight to done; get first
// passes through a read state. Insert and remove at an index move one entry per
// cycle through the single memory read and write port: count - position moves
// (insert) or count - position - 1 moves (remove), then drain and, for insert, fill.
// The next request can be taken in the same cycle that out_valid rises.
// Reset empties the list at once; the store itself needs no clearing.
// The next request is taken while a response still waits under out_stall.
module indexed_array_list_core
  import ial_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ial_in_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output ial_out_t out_rsp
);

  ial_cmd_t cmd;
  ial_sts_t sts;

  ial_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ial_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );

endmodule

// ===== rtl/ial_checker.sv =====
// Port-level checks for the indexed array list core, bound to the top level.
// Depends on ial_pkg.
module ial_checker
  import ial_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input ial_in_t  in_req,
  input logic     out_valid,
  input logic     out_stall,
  input ial_out_t out_rsp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.count <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == ST_FULL |-> out_rsp.count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == ST_EMPTY |-> out_rsp.count == '0)
    else $error("empty status with entries held");

endmodule

bind indexed_array_list_core ial_checker u_ial_checker (.*);

// ===== sim/indexed_array_list_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for indexed_array_list_core: drives list requests,
// predicts every response from its own copy of the list and checks each one.
// Depends on ial_pkg and the indexed_array_list_core RTL.
module indexed_array_list_core_test;
  import ial_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS  = 380;
  localparam int STEADY_ITEMS  = 160;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = CAPACITY + 16;
  localparam int QUIET_LIMIT   = 8000;
  localparam int REPORT_LIMIT  = 10;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ial_in_t  in_req;
  logic     out_valid;
  logic     out_stall;
  ial_out_t out_rsp;

  // Predicted list contents
  logic signed [WORD_W-1:0] list_mem [CAPACITY];
  int       list_len;
  int       peak_len;
  ial_out_t due_rsps[$];

  int  mismatches;
  int  req_sent;
  int  rsp_seen;
  int  status_hits [4];
  bit  steady_flow;
  bit  hold_pending;
  int  hold_left;
  int  quiet_cycles;

  indexed_array_list_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ial_in_t pack_req(input logic [2:0] m, input logic [POS_W-1:0] p,
                                       input logic [WORD_W-1:0] w);
    ial_in_t r;
    r.mode     = m;
    r.position = p;
    r.word_in  = w;
    return r;
  endfunction

  function automatic ial_out_t apply_request(input ial_in_t r);
    ial_out_t rsp;
    int p;
    rsp = '0;
    p = int'(r.position);
    case (r.mode)
      MODE_APPEND: begin
        if (list_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          list_mem[list_len] = r.word_in;
          list_len++;
        end
      end
      MODE_INSERT: begin
        // range test wins over the full test
        if (p > list_len) begin
          rsp.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = r.word_in;
          list_len++;
        end
      end
      MODE_REMOVE_AT: begin
        if (p >= list_len) begin
          rsp.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      MODE_REMOVE_LAST: begin
        if (list_len == 0) rsp.status = ST_EMPTY;
        else list_len--;
      end
      MODE_SET: begin
        if (p >= list_len) rsp.status = ST_RANGE;
        else list_mem[p] = r.word_in;
      end
      MODE_GET: begin
        if (p >= list_len) begin
          rsp.status   = ST_RANGE;
          rsp.word_out = -1;
        end else begin
          rsp.word_out = list_mem[p];
        end
      end
      MODE_CLEAR: list_len = 0;
      default: ;
    endcase
    rsp.count = list_len[CNT_W-1:0];
    if (list_len > peak_len) peak_len = list_len;
    status_hits[rsp.status]++;
    return rsp;
  endfunction

  // Leaves in_valid high on return; the next request or wait_drained settles it.
  task automatic send_req(input ial_in_t req);
    while (!steady_flow && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    due_rsps.push_back(apply_request(req));
    req_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (due_rsps.size() == 0);
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input ial_out_t want, input ial_out_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] %0s: expected status=%0d word=%0d count=%0d, got status=%0d word=%0d count=%0d",
               $time, what, want.status, want.word_out, want.count,
               got.status, got.word_out, got.count);
  endtask

  always @(posedge clk) begin : check_rsp
    ial_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      rsp_seen++;
      if (due_rsps.size() == 0) begin
        report_mismatch("response with no request pending", '0, out_rsp);
      end else begin
        want = due_rsps.pop_front();
        if (out_rsp.status !== want.status || out_rsp.word_out !== want.word_out ||
            out_rsp.count !== want.count)
          report_mismatch("response mismatch", want, out_rsp);
      end
    end
  end

  // Receiver: random stalls, or a long counted hold when one is requested.
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_flow && ($urandom_range(99) < 9);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no request or response moved for %0d cycles", QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic test_directed();
    // empty list: get, remove at, set and insert past the end are out of range, remove last reports empty
    send_req(pack_req(MODE_GET, 0, 0));
    send_req(pack_req(MODE_REMOVE_AT, 0, 0));
    send_req(pack_req(MODE_REMOVE_LAST, 0, 0));
    send_req(pack_req(MODE_SET, 0, 32'h1111_1111));
    send_req(pack_req(MODE_INSERT, 1, 32'h2222_2222));
    send_req(pack_req(MODE_INSERT, 0, 32'h7FFF_FFFF));
    send_req(pack_req(MODE_APPEND, 0, 32'h8000_0000));
    send_req(pack_req(MODE_APPEND, 0, 32'h0000_0000));
    send_req(pack_req(MODE_APPEND, 0, 32'hFFFF_FFFF));
    // insert at the count appends; one past it is rejected
    send_req(pack_req(MODE_INSERT, 4, 32'h5A5A_5A5A));
    send_req(pack_req(MODE_INSERT, 6, 32'h3333_3333));
    send_req(pack_req(MODE_INSERT, 2, 32'h1234_5678));
    send_req(pack_req(MODE_GET, 0, 0));
    send_req(pack_req(MODE_GET, 2, 0));
    send_req(pack_req(MODE_GET, 5, 0));
    send_req(pack_req(MODE_SET, 1, 32'hA5A5_A5A5));
    send_req(pack_req(MODE_GET, 1, 0));
    send_req(pack_req(MODE_REMOVE_AT, 0, 0));
    send_req(pack_req(MODE_REMOVE_AT, 2, 0));
    send_req(pack_req(MODE_REMOVE_AT, 3, 0));
    send_req(pack_req(MODE_GET, 10'h3FF, 0));
    send_req(pack_req(MODE_UNUSED, 10'h3FF, 32'hFFFF_FFFF));
    send_req(pack_req(MODE_REMOVE_LAST, 0, 0));
    send_req(pack_req(MODE_CLEAR, 0, 0));
    send_req(pack_req(MODE_GET, 0, 0));
    wait_drained();
  endtask

  // Hold the receiver off while requests keep coming, so the core backs up.
  task automatic test_backpressure();
    hold_pending = 1'b1;
    repeat (8) begin
      send_req(pack_req(MODE_APPEND, 0, $urandom));
      send_req(pack_req(MODE_GET, 10'(list_len - 1), 0));
    end
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    ial_in_t    r;
    logic [2:0] m;
    int         roll;
    repeat (n_items) begin
      if ($urandom_range(99) < 4) begin
        // noise: any mode, any index
        r = pack_req(3'($urandom_range(7)), 10'($urandom), $urandom);
      end else begin
        if (list_len > 40 && $urandom_range(1) == 1) begin
          m = ($urandom_range(1) == 1) ? MODE_REMOVE_AT : MODE_REMOVE_LAST;
        end else begin
          roll = $urandom_range(99);
          if (roll < 24)      m = MODE_APPEND;
          else if (roll < 42) m = MODE_INSERT;
          else if (roll < 54) m = MODE_REMOVE_AT;
          else if (roll < 62) m = MODE_REMOVE_LAST;
          else if (roll < 76) m = MODE_SET;
          else if (roll < 97) m = MODE_GET;
          else if (roll < 99) m = MODE_CLEAR;
          else                m = MODE_UNUSED;
        end
        r.mode = m;
        if ($urandom_range(99) < 12)
          r.position = 10'($urandom);
        else if (m == MODE_INSERT)
          r.position = 10'($urandom_range(list_len));
        else
          r.position = (list_len == 0) ? '0 : 10'($urandom_range(list_len - 1));
        if ($urandom_range(9) == 0)
          r.word_in = ($urandom_range(1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
          r.word_in = $urandom;
      end
      send_req(r);
    end
    wait_drained();
  endtask

  // Random requests with no idling on either side.
  task automatic test_steady(input int n_items);
    steady_flow = 1'b1;
    test_random(n_items);
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_req       <= '0;
    list_len     = 0;
    peak_len     = 0;
    mismatches   = 0;
    req_sent     = 0;
    rsp_seen     = 0;
    steady_flow  = 1'b0;
    hold_pending = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_steady(STEADY_ITEMS);
    test_backpressure();
    test_random(RANDOM_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_rsps.size() != 0) begin
      $display("%0d responses never arrived", due_rsps.size());
      mismatches += due_rsps.size();
    end
    $display("run covered %0d requests and %0d responses, peak list length %0d",
             req_sent, rsp_seen, peak_len);
    $display("status counts: ok %0d, out of range %0d, empty %0d, full %0d; mismatches %0d",
             status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_EMPTY],
             status_hits[ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
